// ----- src/kslp_pkg.sv -----
package kslp_pkg;

  localparam int MAX_KEYS  = 8;
  localparam int KEY_IDX_W = 3;
  localparam int TICK_W    = 32;
  localparam int HOLD_W    = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam int KEY_COUNT_DEF = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_KEY   = 3'd5;

  localparam logic [63:0]          RST_HOLD_LOW    = 64'd281496451874821000;
  localparam logic [63:0]          RST_HOLD_HIGH   = 64'd844437815230465000;
  localparam logic [MAX_KEYS-1:0]  RST_REPEAT_MASK = '0;
  localparam logic [HOLD_W-1:0]    RST_REPEAT_INT  = 16'd200;
  localparam logic [HOLD_W-1:0]    RST_RELEASE_MIN = 16'd50;
  localparam logic [KEY_IDX_W-1:0] RST_POWER_KEY   = 3'd4;

  // state of one key going into the evaluation unit
  typedef struct packed {
    logic              down;
    logic              was_down;
    logic              locked;
    logic              rep_en;
    logic [TICK_W-1:0] timer;
  } key_state_t;

  // decision for one key coming out of it
  typedef struct packed {
    logic report;
    logic long_press;
    logic locked_nxt;
    logic load_timer;
  } key_dec_t;

endpackage

// ----- src/kslp_key_unit.sv -----
module kslp_key_unit (
  input  kslp_pkg::key_state_t            ks,
  input  logic [kslp_pkg::TICK_W-1:0]     tick_now,
  input  logic [kslp_pkg::HOLD_W-1:0]     hold_time,
  input  logic [kslp_pkg::HOLD_W-1:0]     repeat_interval,
  input  logic [kslp_pkg::HOLD_W-1:0]     release_min_time,
  output kslp_pkg::key_dec_t              dec
);

  logic [kslp_pkg::TICK_W-1:0] elapsed;
  logic [kslp_pkg::HOLD_W-1:0] limit;
  logic                        over;
  logic                        armed;

  // single wrapping subtract and compare shared by every key and case
  assign elapsed = tick_now - ks.timer;
  assign over    = elapsed > {{(kslp_pkg::TICK_W-kslp_pkg::HOLD_W){1'b0}}, limit};
  assign armed   = !ks.locked || ks.rep_en;

  always_comb begin
    if (!ks.down) begin
      limit = release_min_time;
    end else if (ks.locked) begin
      limit = repeat_interval;
    end else begin
      limit = hold_time;
    end
  end

  always_comb begin
    dec = '0;
    if (ks.down) begin
      if (armed) begin
        dec.report     = over;
        dec.long_press = 1'b1;
        dec.locked_nxt = ks.locked || over;
        dec.load_timer = over;
      end else begin
        dec.locked_nxt = 1'b1;
        dec.load_timer = 1'b1;
      end
    end else begin
      dec.report     = ks.was_down && !ks.locked && over;
      dec.long_press = 1'b0;
      dec.locked_nxt = 1'b0;
      dec.load_timer = 1'b1;
    end
  end

endmodule

// ----- src/key_short_long_press_detector.sv -----
// Short/long press detector. Each input beat is one scan (tick time plus key
// levels); keys 0 to KEY_COUNT-1 are then evaluated one per cycle through a
// single subtract-and-compare unit, so a scan holds in_stall high through the
// key walk and a pick state, plus for each report an emit state that
// presents the beat and a pick state for the next. Reports leave in key
// order, the final one of a scan marked by out_last_report; the next scan is
// taken only once every report of the current one has been delivered.
module key_short_long_press_detector #(
  parameter int KEY_COUNT = kslp_pkg::KEY_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kslp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kslp_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kslp_pkg::TICK_W-1:0]       in_tick_now,
  input  logic [kslp_pkg::MAX_KEYS-1:0]     in_key_down_bits,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kslp_pkg::KEY_IDX_W-1:0]    out_key_index,
  output logic                              out_long_press,
  output logic                              out_power_channel,
  output logic                              out_last_report
);

  localparam int NK = kslp_pkg::MAX_KEYS;
  localparam int KW = kslp_pkg::KEY_IDX_W;
  localparam logic [KW-1:0] LAST_KEY = KW'(KEY_COUNT - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PICK, ST_EMIT} state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [63:0]                    hold_low_r, hold_high_r;
  logic [NK-1:0]                  repeat_mask_r;
  logic [kslp_pkg::HOLD_W-1:0]    repeat_int_r, release_min_r;
  logic [KW-1:0]                  power_key_r;

  // per-key state
  logic [kslp_pkg::TICK_W-1:0]    timer_r [NK];
  logic [NK-1:0]                  locked_r, was_down_r;

  // scan context and pending reports
  logic [kslp_pkg::TICK_W-1:0]    tick_r;
  logic [NK-1:0]                  down_r;
  logic [KW-1:0]                  key_r;
  logic [NK-1:0]                  pend_r, pend_nxt;
  logic [NK-1:0]                  kind_r;

  // output register
  logic                           out_valid_r, out_valid_nxt;
  logic [KW-1:0]                  out_key_r, out_key_nxt;
  logic                           out_long_r, out_long_nxt;
  logic                           out_power_r, out_power_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [127:0]                   hold_all;
  logic [kslp_pkg::HOLD_W-1:0]    hold_sel;
  kslp_pkg::key_state_t           ks;
  kslp_pkg::key_dec_t             dec;
  logic                           in_acc, out_acc;
  logic [KW-1:0]                  low_idx;
  logic [NK-1:0]                  low_bit;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  assign hold_all = {hold_high_r, hold_low_r};
  assign hold_sel = hold_all[{key_r, 4'b0000} +: kslp_pkg::HOLD_W];

  assign ks.down     = down_r[key_r];
  assign ks.was_down = was_down_r[key_r];
  assign ks.locked   = locked_r[key_r];
  assign ks.rep_en   = repeat_mask_r[key_r];
  assign ks.timer    = timer_r[key_r];

  kslp_key_unit u_key (
    .ks               (ks),
    .tick_now         (tick_r),
    .hold_time        (hold_sel),
    .repeat_interval  (repeat_int_r),
    .release_min_time (release_min_r),
    .dec              (dec)
  );

  // lowest pending report
  always_comb begin
    low_idx = '0;
    for (int k = NK - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        low_idx = KW'(k);
      end
    end
    low_bit = '0;
    low_bit[low_idx] = 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_long_nxt  = out_long_r;
    out_power_nxt = out_power_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
          pend_nxt  = '0;
        end
      end
      ST_SCAN: begin
        pend_nxt[key_r] = dec.report;
        if (key_r == LAST_KEY) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (pend_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt     = ST_EMIT;
          out_valid_nxt = 1'b1;
          out_key_nxt   = low_idx;
          out_long_nxt  = kind_r[low_idx];
          out_power_nxt = (low_idx == power_key_r);
          out_last_nxt  = (pend_r & ~low_bit) == '0;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          pend_nxt      = pend_r & ~low_bit;
          state_nxt     = ST_PICK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      out_key_r     <= '0;
      out_long_r    <= 1'b0;
      out_power_r   <= 1'b0;
      out_last_r    <= 1'b0;
      pend_r        <= '0;
      key_r         <= '0;
      locked_r      <= '0;
      was_down_r    <= '0;
      for (int k = 0; k < NK; k++) begin
        timer_r[k] <= '0;
      end
      hold_low_r    <= kslp_pkg::RST_HOLD_LOW;
      hold_high_r   <= kslp_pkg::RST_HOLD_HIGH;
      repeat_mask_r <= kslp_pkg::RST_REPEAT_MASK;
      repeat_int_r  <= kslp_pkg::RST_REPEAT_INT;
      release_min_r <= kslp_pkg::RST_RELEASE_MIN;
      power_key_r   <= kslp_pkg::RST_POWER_KEY;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_key_r   <= out_key_nxt;
      out_long_r  <= out_long_nxt;
      out_power_r <= out_power_nxt;
      out_last_r  <= out_last_nxt;
      pend_r      <= pend_nxt;

      if (cfg_we) begin
        case (cfg_index)
          kslp_pkg::CFG_HOLD_LOW:    hold_low_r    <= cfg_wdata;
          kslp_pkg::CFG_HOLD_HIGH:   hold_high_r   <= cfg_wdata;
          kslp_pkg::CFG_REPEAT_MASK: repeat_mask_r <= cfg_wdata[NK-1:0];
          kslp_pkg::CFG_REPEAT_INT:  repeat_int_r  <= cfg_wdata[kslp_pkg::HOLD_W-1:0];
          kslp_pkg::CFG_RELEASE_MIN: release_min_r <= cfg_wdata[kslp_pkg::HOLD_W-1:0];
          kslp_pkg::CFG_POWER_KEY:   power_key_r   <= cfg_wdata[KW-1:0];
          default: ;
        endcase
      end

      if (state_r == ST_IDLE && in_acc) begin
        key_r <= '0;
      end else if (state_r == ST_SCAN) begin
        key_r                <= key_r + 1'b1;
        locked_r[key_r]      <= dec.locked_nxt;
        was_down_r[key_r]    <= ks.down;
        if (dec.load_timer) begin
          timer_r[key_r] <= tick_r;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tick_r <= in_tick_now;
      down_r <= in_key_down_bits;
    end
    if (state_r == ST_SCAN) begin
      kind_r[key_r] <= dec.long_press;
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_key_index     = out_key_r;
  assign out_long_press    = out_long_r;
  assign out_power_channel = out_power_r;
  assign out_last_report   = out_last_r;

  // no scan is taken while a report beat is still on offer
  a_no_accept_while_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready while a report is pending");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall && !out_valid)
    else $error("scan did not start after input beat");

  a_pending_matches_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r[out_key_index] && out_key_index <= LAST_KEY)
    else $error("report beat without pending key");

  a_last_frees_input : assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_last_report |=> ##1 !in_stall)
    else $error("block not idle after final report");

endmodule

// ----- tb/kslp_scan_checker.sv -----
module kslp_scan_checker #(
  parameter int KEY_COUNT = kslp_pkg::KEY_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kslp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kslp_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [kslp_pkg::TICK_W-1:0]       in_tick_now,
  input  logic [kslp_pkg::MAX_KEYS-1:0]     in_key_down_bits,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [kslp_pkg::KEY_IDX_W-1:0]    out_key_index,
  input  logic                              out_long_press,
  input  logic                              out_power_channel,
  input  logic                              out_last_report,
  output int                                mismatches,
  output int                                reports_due
);

  typedef struct packed {
    logic [kslp_pkg::KEY_IDX_W-1:0] key_idx;
    logic                           long_press;
    logic                           power;
    logic                           last;
  } key_report_t;

  // shadow of the register file
  logic [63:0]                    hold_lo;
  logic [63:0]                    hold_hi;
  logic [kslp_pkg::MAX_KEYS-1:0]  rep_mask;
  logic [kslp_pkg::HOLD_W-1:0]    rep_int;
  logic [kslp_pkg::HOLD_W-1:0]    rel_min;
  logic [kslp_pkg::KEY_IDX_W-1:0] pwr_key;

  // per-key shadow state
  logic [kslp_pkg::TICK_W-1:0]    timer_sh  [kslp_pkg::MAX_KEYS];
  logic                           key_lock  [kslp_pkg::MAX_KEYS];
  logic                           key_prev  [kslp_pkg::MAX_KEYS];

  key_report_t          report_q [$];
  int                   fail_n = 0;
  int                   due_n  = 0;

  assign mismatches  = fail_n;
  assign reports_due = due_n;

  task automatic flag(input string what);
    $display("%0t mismatch: %s", $time, what);
    fail_n++;
  endtask

  function automatic key_report_t make_report(input int k, input logic is_long);
    key_report_t r;
    r.key_idx    = k[kslp_pkg::KEY_IDX_W-1:0];
    r.long_press = is_long;
    r.power      = (k[kslp_pkg::KEY_IDX_W-1:0] == pwr_key);
    r.last       = 1'b0;
    return r;
  endfunction

  // walks the keys in index order, updating the shadow state and queueing reports
  task automatic predict_reports(input logic [kslp_pkg::TICK_W-1:0] now,
                                 input logic [kslp_pkg::MAX_KEYS-1:0] levels);
    key_report_t                 scan_rpts [$];
    logic [kslp_pkg::TICK_W-1:0] elapsed;
    logic [kslp_pkg::TICK_W-1:0] limit;
    logic [63:0]                 hold_word;
    logic                        down;
    int                          k;
    for (k = 0; k < KEY_COUNT && k < kslp_pkg::MAX_KEYS; k++) begin
      down    = levels[k];
      elapsed = now - timer_sh[k];
      if (down) begin
        if (!key_lock[k] || rep_mask[k]) begin
          hold_word = (k < 4) ? hold_lo : hold_hi;
          limit = key_lock[k] ? {16'h0, rep_int} : {16'h0, hold_word[(k & 3)*16 +: 16]};
          if (elapsed > limit) begin
            scan_rpts.push_back(make_report(k, 1'b1));
            key_lock[k] = 1'b1;
            timer_sh[k] = now;
          end
        end else begin
          timer_sh[k] = now;
        end
      end else begin
        // short press only from a genuine down-to-up edge of an unlocked key
        if (key_prev[k] && !key_lock[k] && elapsed > {16'h0, rel_min})
          scan_rpts.push_back(make_report(k, 1'b0));
        key_lock[k] = 1'b0;
        timer_sh[k] = now;
      end
      key_prev[k] = down;
    end
    if (scan_rpts.size() > 0)
      scan_rpts[scan_rpts.size()-1].last = 1'b1;
    foreach (scan_rpts[i])
      report_q.push_back(scan_rpts[i]);
  endtask

  always @(posedge clk) begin
    key_report_t want;
    if (!rst_n) begin
      hold_lo  = kslp_pkg::RST_HOLD_LOW;
      hold_hi  = kslp_pkg::RST_HOLD_HIGH;
      rep_mask = kslp_pkg::RST_REPEAT_MASK;
      rep_int  = kslp_pkg::RST_REPEAT_INT;
      rel_min  = kslp_pkg::RST_RELEASE_MIN;
      pwr_key  = kslp_pkg::RST_POWER_KEY;
      for (int k = 0; k < kslp_pkg::MAX_KEYS; k++) begin
        timer_sh[k] = '0;
        key_lock[k] = 1'b0;
        key_prev[k] = 1'b0;
      end
      report_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kslp_pkg::CFG_HOLD_LOW:    hold_lo  = cfg_wdata;
          kslp_pkg::CFG_HOLD_HIGH:   hold_hi  = cfg_wdata;
          kslp_pkg::CFG_REPEAT_MASK: rep_mask = cfg_wdata[kslp_pkg::MAX_KEYS-1:0];
          kslp_pkg::CFG_REPEAT_INT:  rep_int  = cfg_wdata[kslp_pkg::HOLD_W-1:0];
          kslp_pkg::CFG_RELEASE_MIN: rel_min  = cfg_wdata[kslp_pkg::HOLD_W-1:0];
          kslp_pkg::CFG_POWER_KEY:   pwr_key  = cfg_wdata[kslp_pkg::KEY_IDX_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          flag($sformatf("report beat for key %0d with none expected", out_key_index));
        end else begin
          want = report_q.pop_front();
          if (out_key_index !== want.key_idx)
            flag($sformatf("key_index %0d, expected %0d", out_key_index, want.key_idx));
          if (out_long_press !== want.long_press)
            flag($sformatf("long_press %b, expected %b (key %0d)",
                           out_long_press, want.long_press, want.key_idx));
          if (out_power_channel !== want.power)
            flag($sformatf("power_channel %b, expected %b (key %0d)",
                           out_power_channel, want.power, want.key_idx));
          if (out_last_report !== want.last)
            flag($sformatf("last_report %b, expected %b (key %0d)",
                           out_last_report, want.last, want.key_idx));
        end
      end
      if (in_valid && !in_stall)
        predict_reports(in_tick_now, in_key_down_bits);
    end
    // registered so the stimulus side reads a settled count
    due_n <= report_q.size();
  end

endmodule

// ----- tb/tb.sv -----
module tb;

  localparam int KEYS            = kslp_pkg::KEY_COUNT_DEF;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = KEYS + 4;
  localparam int RANDOM_SCANS    = 34;

  // indexes with no register behind them
  localparam logic [kslp_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [kslp_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  logic                            clk              = 1'b0;
  logic                            rst_n            = 1'b0;
  logic                            cfg_we           = 1'b0;
  logic [kslp_pkg::CFG_IDX_W-1:0]  cfg_index        = kslp_pkg::CFG_HOLD_LOW;
  logic [kslp_pkg::CFG_W-1:0]      cfg_wdata        = '0;
  logic                            in_valid         = 1'b0;
  logic [kslp_pkg::TICK_W-1:0]     in_tick_now      = '0;
  logic [kslp_pkg::MAX_KEYS-1:0]   in_key_down_bits = '0;
  logic                            out_stall        = 1'b0;
  logic                            in_stall;
  logic                            out_valid;
  logic [kslp_pkg::KEY_IDX_W-1:0]  out_key_index;
  logic                            out_long_press;
  logic                            out_power_channel;
  logic                            out_last_report;

  int                              idle_pct  = 0;
  int                              stall_pct = 0;
  logic                            hold_off  = 1'b0;
  int                              cycle_cnt = 0;
  int                              mismatches;
  int                              reports_due;
  logic [kslp_pkg::TICK_W-1:0]     tick_q    = '0;
  logic [kslp_pkg::MAX_KEYS-1:0]   level_q   = '0;

  key_short_long_press_detector #(.KEY_COUNT(KEYS)) u_top (.*);

  kslp_scan_checker #(.KEY_COUNT(KEYS)) u_checker (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one scan beat, preceded by random sender idle cycles
  task automatic scan(input logic [kslp_pkg::TICK_W-1:0] t,
                      input logic [kslp_pkg::MAX_KEYS-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_tick_now      <= t;
    in_key_down_bits <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending, let every report drain, then give a reportless scan time to finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [kslp_pkg::MAX_KEYS-1:0] mask,
                              input logic [kslp_pkg::HOLD_W-1:0] rint,
                              input logic [kslp_pkg::HOLD_W-1:0] rmin,
                              input logic [kslp_pkg::KEY_IDX_W-1:0] pk);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_we    <= 1'b1;
    cfg_index <= kslp_pkg::CFG_HOLD_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= kslp_pkg::CFG_HOLD_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= kslp_pkg::CFG_REPEAT_MASK;
    cfg_wdata <= {junk[63:8], mask};
    @(posedge clk);
    cfg_index <= kslp_pkg::CFG_REPEAT_INT;
    cfg_wdata <= {junk[63:16], rint};
    @(posedge clk);
    cfg_index <= kslp_pkg::CFG_RELEASE_MIN;
    cfg_wdata <= {junk[47:0], rmin};
    @(posedge clk);
    cfg_index <= kslp_pkg::CFG_POWER_KEY;
    cfg_wdata <= {junk[63:3], pk};
    @(posedge clk);
    // writes to unused indexes must leave everything alone
    cfg_index <= $urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7;
    cfg_wdata <= ~junk;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly short hold times so long presses and repeats turn up often
  task automatic random_regs();
    logic [63:0] lo;
    logic [63:0] hi;
    int          j;
    for (j = 0; j < 4; j++) begin
      lo[j*16 +: 16] = 16'(($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 250));
      hi[j*16 +: 16] = 16'(($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 250));
    end
    program_regs(lo, hi, 8'($urandom),
                 16'(($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 150)),
                 16'($urandom_range(0, 120)), 3'($urandom_range(0, 7)));
  endtask

  // mostly plausible key activity; the rest is arbitrary levels and tick jumps
  task automatic random_scan();
    int k;
    if ($urandom_range(99) < 85) begin
      for (k = 0; k < kslp_pkg::MAX_KEYS; k++)
        if ($urandom_range(3) == 0) level_q[k] = ~level_q[k];
      tick_q = tick_q + $urandom_range(0, 140);
    end else begin
      level_q = 8'($urandom);
      tick_q  = $urandom_range(1) ? tick_q + $urandom : $urandom;
    end
    scan(tick_q, level_q);
  endtask

  initial begin
    int ph;
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: boot quiet, quick release, shorts on all keys, long + lock, wrap
    scan(32'd0, 8'h00);
    scan(32'd0, 8'hFF);
    scan(32'd10, 8'h00);
    scan(32'd100, 8'hFF);
    scan(32'd200, 8'h00);
    scan(32'd300, 8'hFF);
    scan(32'd70300, 8'hFF);
    scan(32'd80000, 8'hFF);
    scan(32'd90000, 8'h00);
    scan(32'hFFFF_FFFF, 8'h55);
    scan(32'h0000_0100, 8'hAA);
    scan(32'h0000_0200, 8'h00);
    settle();

    // all thresholds zero, repeat on every key
    program_regs(64'h0, 64'h0, 8'hFF, 16'h0, 16'h0, 3'd0);
    scan(32'd5, 8'hFF);
    scan(32'd5, 8'hFF);
    scan(32'd6, 8'hFF);
    scan(32'd6, 8'h00);
    scan(32'd7, 8'h0F);
    scan(32'd7, 8'h00);
    settle();

    // all thresholds at maximum, repeat on the low half only
    program_regs('1, '1, 8'h0F, 16'hFFFF, 16'hFFFF, 3'd7);
    scan(32'h0000_0000, 8'hFF);
    scan(32'h0000_FFFF, 8'hFF);
    scan(32'h0001_0000, 8'hFF);
    scan(32'h0002_0000, 8'h00);
    scan(32'h0002_0000, 8'hFF);
    scan(32'h0003_0001, 8'h00);
    settle();

    tick_q  = $urandom;
    level_q = '0;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 78; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 78; end
        default: begin idle_pct = 6; stall_pct <= 6; end
      endcase
      random_regs();
      if (ph == 0) begin
        // long receiver hold-off while scans keep coming
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      for (n = 0; n < RANDOM_SCANS; n++) begin
        if (ph == 1 && n == RANDOM_SCANS / 2)
          settle();
        random_scan();
      end
      settle();
    end

    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/kslp_pkg.sv
src/kslp_key_unit.sv
src/key_short_long_press_detector.sv
tb/kslp_scan_checker.sv
tb/tb.sv
